// ===== rtl/core/mbd_pkg.sv =====
// Package for the multi-button debouncer: shared constants, payload types and
// the lowest-set-bit helper. No dependencies.

package mbd_pkg;

    // Fixed hardware widths
    localparam int HW_BUTTONS  = 4;
    localparam int IDX_W       = 2;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd4;

    // One poll
    typedef struct packed {
        logic [TIME_W-1:0]     now_ms;
        logic [HW_BUTTONS-1:0] raw_levels;
    } mbd_in_t;

    // One event
    typedef struct packed {
        logic [IDX_W-1:0]  button_index;
        logic              pressed;
        logic [TIME_W-1:0] event_time_ms;
        logic              last_event;
    } mbd_out_t;

    // One poll's worth of settled changes, front to back
    typedef struct packed {
        logic [TIME_W-1:0]     event_time_ms;
        logic [HW_BUTTONS-1:0] event_mask;
        logic [HW_BUTTONS-1:0] pressed_bits;
    } mbd_entry_t;

    // Index of the lowest set bit (zero when none set)
    function automatic logic [IDX_W-1:0] lowest_index(input logic [HW_BUTTONS-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = HW_BUTTONS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/mbd_front.sv =====
// Debouncer front end: takes polls, updates per-button debounce state and
// classifies which buttons settle. Depends on mbd_pkg.

module mbd_front #(
    parameter int ACTIVE = 4
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  mbd_pkg::mbd_in_t                               s_payload,
    input  logic [mbd_pkg::HW_BUTTONS-1:0][mbd_pkg::DEB_W-1:0] debounce_ms,
    input  logic [mbd_pkg::HW_BUTTONS-1:0]                 active_level_mask,
    output logic                                           push_valid,
    input  logic                                           push_ready,
    output mbd_pkg::mbd_entry_t                            push_entry
);

    logic [ACTIVE-1:0]              seeded_reg, seeded_next;
    logic [ACTIVE-1:0]              seen_reg, seen_next;
    logic [ACTIVE-1:0]              stable_reg, stable_next;
    logic [mbd_pkg::TIME_W-1:0]     change_time_reg [ACTIVE];
    logic [mbd_pkg::TIME_W-1:0]     change_time_next [ACTIVE];
    logic [mbd_pkg::HW_BUTTONS-1:0] ev_mask;
    logic [mbd_pkg::HW_BUTTONS-1:0] press_bits;
    logic [mbd_pkg::TIME_W-1:0]     held;
    logic                           raw;
    logic                           accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    // Per-button debounce decision, all buttons in parallel
    always_comb begin
        ev_mask     = '0;
        press_bits  = '0;
        held        = '0;
        raw         = 1'b0;
        seeded_next = seeded_reg;
        seen_next   = seen_reg;
        stable_next = stable_reg;
        for (int i = 0; i < ACTIVE; i++) begin
            change_time_next[i] = change_time_reg[i];
        end
        for (int i = 0; i < ACTIVE; i++) begin
            raw  = s_payload.raw_levels[i];
            held = s_payload.now_ms - change_time_reg[i];
            if (!seeded_reg[i]) begin
                seeded_next[i]      = 1'b1;
                seen_next[i]        = raw;
                stable_next[i]      = raw;
                change_time_next[i] = s_payload.now_ms;
            end else if (raw != seen_reg[i]) begin
                seen_next[i]        = raw;
                change_time_next[i] = s_payload.now_ms;
            end else if (raw != stable_reg[i] &&
                         !(held < {{(mbd_pkg::TIME_W-mbd_pkg::DEB_W){1'b0}}, debounce_ms[i]})) begin
                stable_next[i] = raw;
                ev_mask[i]     = 1'b1;
                press_bits[i]  = ~(raw ^ active_level_mask[i]);
            end
        end
    end

    assign push_valid               = accept && (ev_mask != '0);
    assign push_entry.event_time_ms = s_payload.now_ms;
    assign push_entry.event_mask    = ev_mask;
    assign push_entry.pressed_bits  = press_bits;

    // State update on each accepted poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= '0;
            seen_reg   <= '0;
            stable_reg <= '0;
            for (int i = 0; i < ACTIVE; i++) begin
                change_time_reg[i] <= '0;
            end
        end else if (accept) begin
            seeded_reg <= seeded_next;
            seen_reg   <= seen_next;
            stable_reg <= stable_next;
            for (int i = 0; i < ACTIVE; i++) begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

endmodule

// ===== rtl/core/mbd_queue.sv =====
// Small FIFO of settled-change entries between front and back.
// Depends on mbd_pkg.

module mbd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  mbd_pkg::mbd_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mbd_pkg::mbd_entry_t pop_entry
);

    localparam int PTR_W = $clog2(mbd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mbd_pkg::QUEUE_DEPTH + 1);

    mbd_pkg::mbd_entry_t mem [mbd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(mbd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not advance on push");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");
`endif

endmodule

// ===== rtl/core/mbd_back.sv =====
// Debouncer back end: walks an entry's change mask in button order; unless
// stalled, issues one event per cycle via an output register. Needs mbd_pkg.

module mbd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  mbd_pkg::mbd_entry_t pop_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output mbd_pkg::mbd_out_t   m_payload
);

    logic                           work_valid_reg;
    logic [mbd_pkg::HW_BUTTONS-1:0] work_mask_reg, work_press_reg;
    logic [mbd_pkg::TIME_W-1:0]     work_time_reg;
    logic                           m_valid_reg;
    mbd_pkg::mbd_out_t              m_payload_reg;

    logic                           out_free, emit, emit_last, pop_fire;
    logic [mbd_pkg::IDX_W-1:0]      idx;
    logic [mbd_pkg::HW_BUTTONS-1:0] remaining;

    // Pick the next button to report
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = work_valid_reg && out_free;
    assign idx       = mbd_pkg::lowest_index(work_mask_reg);
    assign remaining = work_mask_reg & ~(mbd_pkg::HW_BUTTONS'(1) << idx);
    assign emit_last = emit && (remaining == '0);
    assign pop_ready = !work_valid_reg || emit_last;
    assign pop_fire  = pop_valid && pop_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Work register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (pop_fire) begin
            work_valid_reg <= 1'b1;
        end else if (emit_last) begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            work_mask_reg  <= pop_entry.event_mask;
            work_press_reg <= pop_entry.pressed_bits;
            work_time_reg  <= pop_entry.event_time_ms;
        end else if (emit) begin
            work_mask_reg <= remaining;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_payload_reg.button_index  <= idx;
            m_payload_reg.pressed       <= work_press_reg[idx];
            m_payload_reg.event_time_ms <= work_time_reg;
            m_payload_reg.last_event    <= (remaining == '0);
        end
    end

`ifndef SYNTH
    a_work_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        work_valid_reg |-> (work_mask_reg != '0))
        else $error("active work entry has no pending change");
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("issued event not presented");
`endif

endmodule

// ===== rtl/core/multi_button_debouncer.sv =====
// Top level of the multi-button debouncer: configuration registers and the
// front, queue and back stages. Depends on mbd_pkg, mbd_front, mbd_queue, mbd_back.

// For each accepted poll the front updates every button's debounce state at
// once and, if any button settles, stores one entry in a two-deep queue.
// The back issues the settled changes of an entry one per cycle in button
// order unless the output is stalled, so a poll with k events (one to four)
// gives k output events; the output register is the limit. Polls with no event
// are taken one per cycle, and the input stalls only while the queue holds two
// entries. Registers: 0..3 debounce time per button in ms, 4 active-level mask.

module multi_button_debouncer #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbd_pkg::mbd_in_t                    s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbd_pkg::mbd_out_t                   m_payload,
    input  logic                                cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int ACTIVE = (NUM_BUTTONS < mbd_pkg::HW_BUTTONS) ? NUM_BUTTONS
                                                                : mbd_pkg::HW_BUTTONS;

    logic [mbd_pkg::HW_BUTTONS-1:0][mbd_pkg::DEB_W-1:0] debounce_reg;
    logic [mbd_pkg::HW_BUTTONS-1:0]                     level_mask_reg;

    logic                push_valid, push_ready, pop_valid, pop_ready;
    mbd_pkg::mbd_entry_t push_entry, pop_entry;

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mbd_pkg::HW_BUTTONS; i++) begin
                debounce_reg[i] <= mbd_pkg::DEBOUNCE_RESET;
            end
            level_mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                [mbd_pkg::REG_DEBOUNCE0:mbd_pkg::REG_DEBOUNCE3]: begin
                    debounce_reg[cfg_index[mbd_pkg::IDX_W-1:0]] <= cfg_wdata;
                end
                mbd_pkg::REG_ACTIVE_MASK: begin
                    level_mask_reg <= cfg_wdata[mbd_pkg::HW_BUTTONS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mbd_front #(
        .ACTIVE(ACTIVE)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_payload         (s_payload),
        .debounce_ms       (debounce_reg),
        .active_level_mask (level_mask_reg),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_entry        (push_entry)
    );

    mbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
